// ----- hdl/lsr_pkg.sv -----
// Shared constants for the linear ADSR envelope unit.
// Holds command codes, register indexes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package lsr_pkg;

  // Fixed field widths.
  localparam int LEN_W   = 24;
  localparam int SUS_W   = 16;
  localparam int STEP_W  = 13;
  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE  = 2'd2;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RELEASE = 2'd3;

  // Reset value of the sustain register.
  localparam logic [SUS_W-1:0] SUSTAIN_RESET = 16'd32768;

endpackage

// ----- hdl/linear_adsr_envelope_unit.sv -----
// Top level of the linear ADSR envelope unit: registers, sequencer, output stage.
// Depends on lsr_pkg and lsr_muldiv.
`timescale 1ns / 1ps

// Linear ADSR envelope for one voice. Note on and note off transactions
// reset the sample count and return a zero result. An advance transaction
// that lands inside the attack, decay or release ramp runs the shared
// multiply-divide unit, one quotient bit per cycle; an advance in sustain
// or past the end of release does not use it. The input is stalled while a
// transaction is being worked; a finished result sits in the output
// register, so the next transaction can be taken while it waits.
// Configuration writes take effect at once and are meant for idle periods.
module linear_adsr_envelope_unit #(
  parameter int COUNT_BITS      = 24,
  parameter int LEVEL_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsr_pkg::CMD_W-1:0]    cmd,
  input  logic [lsr_pkg::STEP_W-1:0]   step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsr_pkg::LEVEL_W-1:0]  level,
  output logic                         done_res,
  input  logic                         cfg_wen,
  input  logic [lsr_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [lsr_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int LEN_W = lsr_pkg::LEN_W;
  localparam int LW    = LEVEL_FRAC_BITS + 1;
  localparam int EW    = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
  localparam int SW    = ((COUNT_BITS > lsr_pkg::STEP_W) ? COUNT_BITS : lsr_pkg::STEP_W) + 1;
  localparam logic [LW-1:0] FULL = LW'(1) << LEVEL_FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] SEG_ATTACK  = 2'd0;
  localparam logic [1:0] SEG_DECAY   = 2'd1;
  localparam logic [1:0] SEG_RELEASE = 2'd2;

  // Configuration registers.
  logic [LEN_W-1:0]         attack_len;
  logic [LEN_W-1:0]         decay_len;
  logic [lsr_pkg::SUS_W-1:0] sustain_level;
  logic [LEN_W-1:0]         release_len;

  // Envelope state and sequencer.
  logic [1:0]               state;
  logic [COUNT_BITS-1:0]    sample_count;
  logic                     gate_on;
  logic [LW-1:0]            held_level;
  logic [lsr_pkg::CMD_W-1:0]  cmd_q;
  logic [lsr_pkg::STEP_W-1:0] step_q;
  logic [1:0]               seg;
  logic [LW-1:0]            res_level;
  logic                     res_done;

  // Shared unit hookup.
  logic                     div_start;
  logic [LEN_W-1:0]         div_m;
  logic [LW-1:0]            div_x;
  logic [LEN_W-1:0]         div_d;
  logic                     div_done;
  logic [LW-1:0]            div_q;

  // Evaluation terms.
  logic [LW-1:0]            sus_c;
  logic [EW-1:0]            c_e;
  logic [EW-1:0]            ca_diff;
  logic                     in_attack;
  logic                     in_decay;
  logic                     in_release;
  logic                     need_div;
  logic [1:0]               seg_next;
  logic [SW-1:0]            count_sum;
  logic [COUNT_BITS-1:0]    count_next;
  logic [LW-1:0]            div_level;
  logic                     slot_free;
  logic [31:0]              level_wide;

  // Sustain clamped to full scale.
  assign sus_c = (32'(sustain_level) > 32'(FULL)) ? FULL : LW'(sustain_level);

  // Segment decision at the current count.
  assign c_e        = EW'(sample_count);
  assign ca_diff    = c_e - EW'(attack_len);
  assign in_attack  = c_e < EW'(attack_len);
  assign in_decay   = ca_diff < EW'(decay_len);
  assign in_release = c_e < EW'(release_len);

  // Operand selection for the shared unit.
  always_comb begin
    need_div = 1'b0;
    seg_next = SEG_ATTACK;
    div_m    = c_e[LEN_W-1:0];
    div_x    = FULL;
    div_d    = attack_len;
    if (gate_on) begin
      if (in_attack) begin
        need_div = 1'b1;
        div_x    = (decay_len == '0) ? sus_c : FULL;
      end else if (in_decay) begin
        need_div = 1'b1;
        seg_next = SEG_DECAY;
        div_m    = ca_diff[LEN_W-1:0];
        div_x    = FULL - sus_c;
        div_d    = decay_len;
      end
    end else if (in_release) begin
      need_div = 1'b1;
      seg_next = SEG_RELEASE;
      div_x    = held_level;
      div_d    = release_len;
    end
  end

  assign div_start = (state == S_EVAL) && (cmd_q == lsr_pkg::CMD_ADVANCE) && need_div;

  // Saturating count advance.
  assign count_sum  = SW'(sample_count) + SW'(step_q);
  assign count_next = (|count_sum[SW-1:COUNT_BITS]) ? '1 : count_sum[COUNT_BITS-1:0];

  // Final level from the quotient.
  always_comb begin
    case (seg)
      SEG_ATTACK:  div_level = div_q;
      SEG_DECAY:   div_level = FULL - div_q;
      SEG_RELEASE: div_level = held_level - div_q;
      default:     div_level = '0;
    endcase
  end

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  lsr_muldiv #(
    .MW(LEN_W),
    .QW(LW)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mcand   (div_m),
    .mplier  (div_x),
    .divisor (div_d),
    .done    (div_done),
    .quot    (div_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= '0;
      decay_len     <= '0;
      sustain_level <= lsr_pkg::SUSTAIN_RESET;
      release_len   <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        lsr_pkg::REG_ATTACK:  attack_len    <= cfg_data[LEN_W-1:0];
        lsr_pkg::REG_DECAY:   decay_len     <= cfg_data[LEN_W-1:0];
        lsr_pkg::REG_SUSTAIN: sustain_level <= cfg_data[lsr_pkg::SUS_W-1:0];
        lsr_pkg::REG_RELEASE: release_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      gate_on      <= 1'b0;
      held_level   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (cmd_q)
            lsr_pkg::CMD_NOTE_ON: begin
              sample_count <= '0;
              gate_on      <= 1'b1;
              state        <= S_OUT;
            end
            lsr_pkg::CMD_NOTE_OFF: begin
              sample_count <= '0;
              gate_on      <= 1'b0;
              state        <= S_OUT;
            end
            lsr_pkg::CMD_ADVANCE: begin
              sample_count <= count_next;
              if (need_div) begin
                state <= S_WAIT;
              end else begin
                if (gate_on) begin
                  held_level <= sus_c;
                end
                state <= S_OUT;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_WAIT: begin
          if (div_done) begin
            if (seg != SEG_RELEASE) begin
              held_level <= div_level;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Transaction payload and result staging.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q  <= cmd;
      step_q <= step;
    end
    if (state == S_EVAL) begin
      seg       <= seg_next;
      res_level <= '0;
      res_done  <= 1'b0;
      if (cmd_q == lsr_pkg::CMD_ADVANCE && !need_div) begin
        res_level <= gate_on ? sus_c : '0;
        res_done  <= !gate_on;
      end
    end
    if (state == S_WAIT && div_done) begin
      res_level <= div_level;
    end
  end

  // Output register.
  assign level_wide = {{(32 - LW){1'b0}}, res_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && slot_free) begin
      level    <= level_wide[lsr_pkg::LEVEL_W-1:0];
      done_res <= res_done;
    end
  end

  // The shared unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT))
    else $error("divide result arrived outside the wait state");

  // An accepted transaction is evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("accepted transaction was not evaluated");

  // A finished release always reports a zero level.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (level == '0))
    else $error("done result with nonzero level");

endmodule

// ----- hdl/lsr_muldiv.sv -----
// Shared multiply-then-divide unit: quotient of (mcand * mplier) / divisor.
// One multiply step, then one restoring quotient bit per cycle.
// Uses lsr_pkg for nothing; widths come from parameters.
`timescale 1ns / 1ps

module lsr_muldiv #(
  parameter int MW = 24,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] mcand,
  input  logic [QW-1:0] mplier,
  input  logic [MW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quot
);

  // The caller guarantees mcand < divisor, so the quotient is no greater than mplier.
  localparam int PW   = MW + QW;
  localparam int CNTW = $clog2(QW);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]      state;
  logic [CNTW-1:0] cnt;
  logic [MW-1:0]   m_q;
  logic [QW-1:0]   x_q;
  logic [MW-1:0]   d_q;
  logic [MW-1:0]   rem;
  logic [QW-1:0]   low;

  logic [PW-1:0] product;
  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic          fits;

  // Product of the captured operands, registered into the divider.
  assign product = PW'(m_q) * PW'(x_q);

  // One restoring step: bring down the next bit and try the subtract.
  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = (trial >= {1'b0, d_q});

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            state <= U_MUL;
          end
        end
        U_MUL: begin
          cnt   <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(QW - 1)) begin
            state <= U_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  // Operand capture and the shifting remainder and quotient.
  always_ff @(posedge clk) begin
    if (state == U_IDLE && start) begin
      m_q <= mcand;
      x_q <= mplier;
      d_q <= divisor;
    end
    if (state == U_MUL) begin
      rem <= product[PW-1:QW];
      low <= product[QW-1:0];
    end else if (state == U_DIV) begin
      rem <= fits ? diff[MW-1:0] : trial[MW-1:0];
      low <= {low[QW-2:0], fits};
    end
  end

  assign quot = low;

endmodule

// ----- tb/linear_adsr_envelope_unit_tb.sv -----
// Self-checking testbench for linear_adsr_envelope_unit.
// Depends on lsr_pkg and the unit itself; carries its own envelope predictor
// and checks every output transaction against it.
`timescale 1ns / 1ps

module linear_adsr_envelope_unit_tb;

  localparam int CMD_W   = lsr_pkg::CMD_W;
  localparam int STEP_W  = lsr_pkg::STEP_W;
  localparam int LEVEL_W = lsr_pkg::LEVEL_W;
  localparam int LEN_W   = lsr_pkg::LEN_W;
  localparam int SUS_W   = lsr_pkg::SUS_W;
  localparam int CFG_AW  = lsr_pkg::CFG_AW;
  localparam int CFG_DW  = lsr_pkg::CFG_DW;

  localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam longint unsigned   FULL_SCALE    = 64'd32768;
  localparam logic [LEN_W-1:0]  COUNT_MAX     = '1;
  localparam int                SETTLE_CYCLES = 32;
  localparam int                MAX_REPORTS   = 10;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               done;
  } envelope_result_t;

  // DUT ports; the driven inputs are known from time zero.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd       = '0;
  logic [STEP_W-1:0]   step      = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LEVEL_W-1:0]  level;
  logic                done_res;
  logic                cfg_wen   = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data  = '0;

  // Envelope predictor: register mirror and voice state.
  logic [LEN_W-1:0]    attack_q  = '0;
  logic [LEN_W-1:0]    decay_q   = '0;
  logic [SUS_W-1:0]    sustain_q = lsr_pkg::SUSTAIN_RESET;
  logic [LEN_W-1:0]    release_q = '0;
  logic [LEN_W-1:0]    count_q   = '0;
  logic                gate_q    = 1'b0;
  logic [LEVEL_W-1:0]  held_q    = '0;

  envelope_result_t    expected_levels[$];
  int                  mismatch_count = 0;
  int                  accepted_items = 0;

  // Sender burst control and receiver stall control.
  bit                  gaps_on    = 1'b1;
  int                  burst_left = 0;
  int                  stall_pct  = 0;
  int                  hold_request = 0;
  int                  hold_left  = 0;
  int                  stall_run  = 0;
  bit                  stall_now  = 1'b0;

  linear_adsr_envelope_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .step      (step),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .done_res  (done_res),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Level while the gate is open, at sample count c.
  function automatic longint unsigned open_gate_level(input longint unsigned c);
    longint unsigned sus, a, d;
    sus = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;
    a = attack_q;
    d = decay_q;
    if (c < a) begin
      if (d == 0) return (c * sus) / a;
      return (c * FULL_SCALE) / a;
    end
    if (c - a < d) return FULL_SCALE - ((c - a) * (FULL_SCALE - sus)) / d;
    return sus;
  endfunction

  // Advance the predicted voice by one transaction and queue its result.
  task automatic predict_envelope(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] s);
    envelope_result_t r;
    longint unsigned cnt, lvl, held, nxt;
    r = '0;
    case (c)
      lsr_pkg::CMD_NOTE_ON: begin
        count_q = '0;
        gate_q = 1'b1;
      end
      lsr_pkg::CMD_NOTE_OFF: begin
        count_q = '0;
        gate_q = 1'b0;
      end
      lsr_pkg::CMD_ADVANCE: begin
        cnt = count_q;
        held = held_q;
        lvl = 0;
        if (gate_q) begin
          lvl = open_gate_level(cnt);
          held_q = lvl[LEVEL_W-1:0];
        end else if (cnt < release_q) begin
          lvl = held - (cnt * held) / release_q;
        end else begin
          r.done = 1'b1;
        end
        r.level = lvl[LEVEL_W-1:0];
        nxt = cnt + s;
        count_q = (nxt > COUNT_MAX) ? COUNT_MAX : nxt[LEN_W-1:0];
      end
      default: begin
      end
    endcase
    expected_levels.push_back(r);
  endtask

  task automatic log_mismatch(input string what, input envelope_result_t want,
                              input envelope_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected level %0d done %0b, got level %0d done %0b",
               $time, what, want.level, want.done, got.level, got.done);
  endtask

  // Output checker: every accepted transaction against the oldest prediction.
  always @(posedge clk) begin
    envelope_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.level = level;
      got.done = done_res;
      if (expected_levels.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = expected_levels.pop_front();
        if (got.level !== want.level || got.done !== want.done)
          log_mismatch("wrong result", want, got);
      end
    end
  end

  // Receiver: runs of stall and no stall, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_now = ($urandom_range(0, 99) < stall_pct);
        stall_run = $urandom_range(1, 6);
      end
      stall_run--;
      out_stall <= stall_now;
    end
  end

  // Offer one transaction and hold it until the unit takes it.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] s);
    in_valid <= 1'b1;
    cmd <= c;
    step <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_envelope(c, s);
    accepted_items++;
  endtask

  // Send with the sender's burst pattern: random bursts, random gaps.
  task automatic offer_item(input logic [CMD_W-1:0] c, input logic [STEP_W-1:0] s);
    send_item(c, s);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Wait until every predicted result has come out and the unit has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      lsr_pkg::REG_ATTACK:  attack_q = value;
      lsr_pkg::REG_DECAY:   decay_q = value;
      lsr_pkg::REG_SUSTAIN: sustain_q = value[SUS_W-1:0];
      lsr_pkg::REG_RELEASE: release_q = value;
      default: begin
      end
    endcase
  endtask

  // Load all four registers while the unit is idle.
  task automatic apply_envelope_config(input logic [CFG_DW-1:0] a, input logic [CFG_DW-1:0] d,
                                       input logic [CFG_DW-1:0] s, input logic [CFG_DW-1:0] r);
    drain_results();
    write_register(lsr_pkg::REG_ATTACK, a);
    write_register(lsr_pkg::REG_DECAY, d);
    write_register(lsr_pkg::REG_SUSTAIN, s);
    write_register(lsr_pkg::REG_RELEASE, r);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DW-1:0] pick_length(input int kind);
    case (kind)
      0: return '0;
      1: return CFG_DW'($urandom_range(1, 64));
      2: return CFG_DW'($urandom_range(65, 8192));
      3: return CFG_DW'($urandom_range(8193, 24'hFFFFFF));
      default: return '1;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_sustain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_DW'(32768);
      2: return CFG_DW'(16'hFFFF);
      3: return CFG_DW'($urandom_range(32769, 65535));
      default: return CFG_DW'($urandom_range(0, 32768));
    endcase
  endfunction

  // Advance and unused command straight out of reset.
  task automatic test_reset_defaults();
    gaps_on = 1'b0;
    stall_pct = 0;
    offer_item(lsr_pkg::CMD_ADVANCE, '0);
    offer_item(CMD_UNUSED, '1);
  endtask

  // Attack, decay, sustain and release in turn with short segments.
  task automatic test_full_envelope();
    apply_envelope_config(24'd4, 24'd4, 24'd16384, 24'd4);
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd2);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd3);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd2);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd8191);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd0);
    offer_item(lsr_pkg::CMD_NOTE_OFF, 13'd8191);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd2);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd0);
  endtask

  // Zero decay ramps attack to a clamped sustain; zero release is done at once.
  task automatic test_zero_segments();
    apply_envelope_config(24'd8, 24'd0, 24'hFFFF, 24'd0);
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd4);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd4);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
    offer_item(lsr_pkg::CMD_NOTE_OFF, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd0);
  endtask

  // The unused command in the middle of an attack leaves the voice alone.
  task automatic test_unused_command();
    apply_envelope_config(24'd16, 24'd16, 24'd0, 24'd16);
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
    offer_item(CMD_UNUSED, 13'd8191);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
  endtask

  // One note with random content; now and then broken or mixed with noise.
  task automatic send_note_sequence(input int step_cap);
    int n;
    if ($urandom_range(0, 9) == 0)
      offer_item(CMD_W'($urandom_range(0, 3)), STEP_W'($urandom_range(0, 8191)));
    offer_item(lsr_pkg::CMD_NOTE_ON, STEP_W'($urandom_range(0, 8191)));
    n = $urandom_range(1, 30);
    repeat (n) offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(0, step_cap)));
    if ($urandom_range(0, 9) == 0)
      offer_item(CMD_UNUSED, STEP_W'($urandom_range(0, 8191)));
    if ($urandom_range(0, 9) != 0)
      offer_item(lsr_pkg::CMD_NOTE_OFF, STEP_W'($urandom_range(0, 8191)));
    n = $urandom_range(1, 30);
    repeat (n) offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(0, step_cap)));
  endtask

  // Random phases, each with its own register setting and idling pattern.
  task automatic test_random_phases();
    int caps[4] = '{16, 256, 4096, 8191};
    int pcts[4] = '{0, 20, 50, 80};
    int start, cap;
    for (int p = 0; p < 8; p++) begin
      if (p == 0)
        apply_envelope_config('1, '1, '0, '1);
      else if (p == 1)
        apply_envelope_config('0, '0, CFG_DW'(32768), '0);
      else
        apply_envelope_config(pick_length($urandom_range(0, 4)),
                              pick_length($urandom_range(0, 4)),
                              pick_sustain(), pick_length($urandom_range(0, 4)));
      cap = (p == 0) ? 8191 : caps[$urandom_range(0, 3)];
      stall_pct = pcts[$urandom_range(0, 3)];
      gaps_on = ($urandom_range(0, 3) != 0);
      start = accepted_items;
      while (accepted_items - start < 125) send_note_sequence(cap);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    apply_envelope_config(24'd64, 24'd64, 24'd10000, 24'd64);
    gaps_on = 1'b0;
    stall_pct = 0;
    hold_request = 300;
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    repeat (7) offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(0, 20)));
    offer_item(lsr_pkg::CMD_NOTE_OFF, 13'd0);
    repeat (7) offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(0, 20)));
  endtask

  // Run the count up to its ceiling in release, where wrapping would show.
  task automatic test_count_saturation();
    apply_envelope_config(24'd2, 24'd2, 24'd20000, '1);
    gaps_on = 1'b0;
    stall_pct = 20;
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd5);
    offer_item(lsr_pkg::CMD_NOTE_OFF, 13'd0);
    while (count_q != COUNT_MAX)
      offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(6000, 8191)));
    repeat (3) offer_item(lsr_pkg::CMD_ADVANCE, STEP_W'($urandom_range(0, 8191)));
    offer_item(lsr_pkg::CMD_NOTE_ON, 13'd0);
    offer_item(lsr_pkg::CMD_ADVANCE, 13'd1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_envelope();
    test_zero_segments();
    test_unused_command();
    test_random_phases();
    test_output_backpressure();
    test_count_saturation();
    drain_results();
    if (mismatch_count == 0) begin
      $display("linear_adsr_envelope_unit: match");
    end else begin
      $display("linear_adsr_envelope_unit: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("linear_adsr_envelope_unit: mismatch");
    $finish;
  end

endmodule
